// ===== rtl/core/yli_pkg.sv =====
package yli_pkg;

    localparam int DEF_IMAGE_WIDTH  = 640;
    localparam int DEF_IMAGE_HEIGHT = 480;

    // Q10 color coefficients
    localparam logic signed [11:0] K_RV = 12'sd1441;
    localparam logic signed [11:0] K_GU = 12'sd354;
    localparam logic signed [11:0] K_GV = 12'sd734;
    localparam logic signed [11:0] K_BU = 12'sd1822;

    typedef enum logic [1:0] {
        ACT_CONV  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [31:0] word;
        logic [9:0]  x;
        logic [8:0]  y;
        logic        first_ok;   // first pixel (or read point) inside image
        logic        second_ok;  // second pixel inside image
    } t_item;

    typedef struct packed {
        logic        color_mode;
        logic [15:0] divisor;
    } t_cfg;

    typedef struct packed {
        logic clearing;
        logic idle;
    } t_status;

    // negative -> 0, else >>10 capped at 255
    function automatic logic [7:0] to_byte(input logic signed [23:0] q10);
        logic [13:0] v;
        v = q10[23:10];
        if (q10[23])
            return 8'd0;
        else if (v > 14'd255)
            return 8'd255;
        else
            return v[7:0];
    endfunction

endpackage

// ===== rtl/core/yli_front.sv =====
module yli_front
    import yli_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    output logic        o_q_valid,
    input  logic        i_q_ready,
    output t_item       o_q_item
);

    t_item       w_item;
    t_item       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push, w_pop;
    logic [12:0] w_x, w_y;

    always_comb begin
        w_x              = {3'b0, i_s_tdata[41:32]};
        w_y              = {4'b0, i_s_tdata[50:42]};
        w_item.action    = t_action'(i_s_tuser);
        w_item.word      = i_s_tdata[31:0];
        w_item.x         = i_s_tdata[41:32];
        w_item.y         = i_s_tdata[50:42];
        w_item.first_ok  = (w_x < 13'(IMAGE_WIDTH)) && (w_y < 13'(IMAGE_HEIGHT));
        w_item.second_ok = ((w_x + 13'd1) < 13'(IMAGE_WIDTH)) && (w_y < 13'(IMAGE_HEIGHT));
    end

    assign o_s_tready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_mem[r_rp];
    assign w_push     = i_s_tvalid && o_s_tready;
    assign w_pop      = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ===== rtl/core/yli_back.sv =====
module yli_back
    import yli_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    output logic        o_q_ready,
    input  t_item       i_q_item,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,
    output t_status     o_status
);

    localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_RD   = 8'b0000_0100,
        S_WR   = 8'b0000_1000,
        S_CHK  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_CLR  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state              r_state;
    t_item               r_item;
    logic [AW-1:0]       r_addr, r_clr;
    logic                r_pix, r_boot;
    logic [31:0]         r_rdata;
    logic [31:0]         r_mem [DEPTH];
    logic signed [21:0]  r_rv, r_gu, r_gv, r_bu;
    logic [23:0]         r_rem;
    logic [7:0]          r_quot;
    logic [2:0]          r_bit;
    logic                r_ovalid;
    logic [55:0]         r_out;

    logic [AW-1:0]       w_raddr, w_waddr;
    logic [31:0]         w_wdata;
    logic                w_we;
    logic [32:0]         w_sum;
    logic [7:0]          w_luma;
    logic [15:0]         w_div;
    logic [23:0]         w_dsh;
    logic signed [9:0]   w_d, w_e;
    logic [55:0]         w_res;
    logic                w_load;

    // pixel color for one luma against the pair's chroma products
    function automatic logic [23:0] pix_rgb(input logic [7:0] lum, input logic cm,
            input logic signed [21:0] rv, input logic signed [21:0] gu,
            input logic signed [21:0] gv, input logic signed [21:0] bu);
        logic signed [23:0] base;
        base = $signed({6'b0, lum, 10'b0});
        if (cm)
            return {to_byte(base + 24'(bu)),
                    to_byte(base - 24'(gu) - 24'(gv)),
                    to_byte(base + 24'(rv))};
        else
            return {lum, lum, lum};
    endfunction

    assign w_div   = (i_cfg.divisor == 16'd0) ? 16'd1 : i_cfg.divisor;
    assign w_dsh   = 24'(w_div) << r_bit;
    assign w_raddr = r_addr + AW'(r_pix);
    assign w_luma  = r_pix ? r_item.word[23:16] : r_item.word[7:0];
    assign w_sum   = {1'b0, r_rdata} + 33'(w_luma);
    assign w_d     = $signed({2'b0, r_item.word[15:8]}) - 10'sd128;
    assign w_e     = $signed({2'b0, r_item.word[31:24]}) - 10'sd128;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_raddr;
        w_wdata = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
        if (r_state == S_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = 32'd0;
        end else if (r_state == S_WR) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        w_res = '0;
        unique case (r_item.action)
            ACT_CONV: begin
                w_res[23:0]  = pix_rgb(r_item.word[7:0], i_cfg.color_mode,
                                       r_rv, r_gu, r_gv, r_bu);
                w_res[47:24] = pix_rgb(r_item.word[23:16], i_cfg.color_mode,
                                       r_rv, r_gu, r_gv, r_bu);
            end
            ACT_READ:  w_res[55:48] = r_quot;
            ACT_CLEAR: w_res = '0;
            ACT_NONE:  w_res = '0;
        endcase
    end

    assign w_load     = (r_state == S_OUT) && (!r_ovalid || i_m_tready);
    assign o_q_ready  = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_out;
    assign o_status.clearing = (r_state == S_CLR);
    assign o_status.idle     = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (w_load) r_out <= w_res;
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_boot   <= 1'b1;
            r_ovalid <= 1'b0;
            r_pix    <= 1'b0;
        end else begin
            if (w_load)
                r_ovalid <= 1'b1;
            else if (i_m_tready)
                r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_item;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_addr <= AW'(32'(r_item.y) * 32'(IMAGE_WIDTH) + 32'(r_item.x));
                    r_rv   <= 22'(w_e * K_RV);
                    r_gu   <= 22'(w_d * K_GU);
                    r_gv   <= 22'(w_e * K_GV);
                    r_bu   <= 22'(w_d * K_BU);
                    r_quot <= 8'd0;
                    r_pix  <= 1'b0;
                    unique case (r_item.action)
                        ACT_CONV: begin
                            if (r_item.first_ok) begin
                                r_state <= S_RD;
                            end else if (r_item.second_ok) begin
                                r_pix   <= 1'b1;
                                r_state <= S_RD;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        ACT_READ:  r_state <= r_item.first_ok ? S_RD : S_OUT;
                        ACT_CLEAR: begin
                            r_clr   <= '0;
                            r_state <= S_CLR;
                        end
                        ACT_NONE:  r_state <= S_OUT;
                    endcase
                end
                S_RD: begin
                    r_state <= (r_item.action == ACT_READ) ? S_CHK : S_WR;
                end
                S_WR: begin
                    if (!r_pix && r_item.second_ok) begin
                        r_pix   <= 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_CHK: begin
                    if (r_rdata >= {8'b0, w_div, 8'b0}) begin
                        r_quot  <= 8'd255;
                        r_state <= S_OUT;
                    end else begin
                        r_rem   <= r_rdata[23:0];
                        r_bit   <= 3'd7;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_rem >= w_dsh) begin
                        r_rem         <= r_rem - w_dsh;
                        r_quot[r_bit] <= 1'b1;
                    end
                    if (r_bit == 3'd0)
                        r_state <= S_OUT;
                    else
                        r_bit <= r_bit - 3'd1;
                end
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_boot  <= 1'b0;
                        r_state <= r_boot ? S_IDLE : S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/yuyv_to_rgb_luma_integrator.sv =====
// YUYV 4:2:2 to RGB converter with per-pixel luma integration. Each transfer
// on the slave stream carries one action in tuser: convert a pixel pair
// (returns two RGB pixels, BT.601 Q10 coefficients, or grey when color_mode
// is 0, and adds both lumas into saturating 32-bit per-pixel sums), read the
// average at one pixel (sum / frame_divisor, capped at 255, divisor 0 acts
// as 1), or clear the sum store. Every action yields exactly one master
// transfer. Items are handled one at a time by the back end sequencer:
// a pair does one sum RAM read and write per in-image pixel, a read
// outside the image skips the sum RAM, a read whose average saturates
// skips the 8-step divider, and a clear writes zero to every sum. After
// reset the sum store is swept to zero, all IMAGE_WIDTH*IMAGE_HEIGHT
// entries (307200 at the default size), during which up to two items are
// buffered and then the input stalls. A 2-entry queue decouples input
// from the sequencer and an output register holds results, so either
// side may stall on its own. Configuration writes (index 0 color_mode,
// 1 frame_divisor) are always ready and must only be issued while the
// block is idle.
module yuyv_to_rgb_luma_integrator
    import yli_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // yuyv_word[31:0], x_pos[41:32], y_pos[50:42], zero pad
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // red_first, green_first, blue_first, red_second,
                                        // green_second, blue_second, average_level (8b each)
);

    t_cfg    r_cfg;
    t_item   w_q_item;
    logic    w_q_valid, w_q_ready;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_mode <= 1'b1;
            r_cfg.divisor    <= 16'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 1'b0)
                r_cfg.color_mode <= i_cfg_data[0];
            else
                r_cfg.divisor <= i_cfg_data;
        end
    end

    yli_front #(
        .IMAGE_WIDTH (IMAGE_WIDTH),
        .IMAGE_HEIGHT(IMAGE_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .o_s_tready(s_axis_tready),
        .i_s_tdata (s_axis_tdata),
        .i_s_tuser (s_axis_tuser),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_item  (w_q_item)
    );

    yli_back #(
        .IMAGE_WIDTH (IMAGE_WIDTH),
        .IMAGE_HEIGHT(IMAGE_HEIGHT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q_item  (w_q_item),
        .o_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready),
        .o_m_tdata (m_axis_tdata),
        .o_status  (w_status)
    );

`ifndef ASSERT_OFF
    // the sequencer never takes an item while sweeping the sum store
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.clearing |-> !(w_q_valid && w_q_ready))
        else $error("item taken during clear sweep");

    // queue hands over only when the sequencer is idle
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_ready |-> w_status.idle)
        else $error("queue ready outside idle");

    // reset drops any pending result
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule

// ===== test/tb_yuyv_to_rgb_luma_integrator.sv =====
module tb_yuyv_to_rgb_luma_integrator;
    import yli_pkg::*;

    localparam int IMG_W      = DEF_IMAGE_WIDTH;
    localparam int IMG_H      = DEF_IMAGE_HEIGHT;
    localparam int IDLE_LIMIT = 1000000;  // must outlast a clear sweep of every sum
    localparam int CFG_COLOR  = 0;
    localparam int CFG_DIV    = 1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;

    yuyv_to_rgb_luma_integrator uut (.*);

    // predictor state
    logic        pred_color;
    logic [15:0] pred_div;
    logic [31:0] pred_sums [int];     // absent entry reads as zero

    logic [55:0] pixel_queue [$];      // expected master transfers, oldest first
    int          fail_cnt;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;          // long receiver hold-off, counted down below
    int          quiet_cycles;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] clamp_q10(input int q10);
        if (q10 < 0) return 8'd0;
        if ((q10 >>> 10) > 255) return 8'd255;
        return 8'((q10 >>> 10));
    endfunction

    function automatic logic [23:0] pixel_rgb(input logic [7:0] luma, input int d, input int e);
        int base;
        base = int'(luma) * 1024;
        if (!pred_color) return {luma, luma, luma};   // packed {blue, green, red}
        return {clamp_q10(base + 1822 * d),
                clamp_q10(base - 354 * d - 734 * e),
                clamp_q10(base + 1441 * e)};
    endfunction

    function automatic void add_luma(input int x, input int y, input logic [7:0] luma);
        logic [32:0] s;
        int          idx;
        if (x >= IMG_W || y >= IMG_H) return;
        idx = y * IMG_W + x;
        s = (pred_sums.exists(idx) ? pred_sums[idx] : 32'd0) + luma;
        pred_sums[idx] = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // returns the expected master tdata for one accepted slave transfer
    function automatic logic [55:0] predict_transfer(input t_action act, input logic [31:0] word,
                                                     input int x, input int y);
        logic [55:0] res;
        logic [31:0] q;
        int          d, e, idx;
        res = '0;
        case (act)
            ACT_CONV: begin
                d = int'(word[15:8]) - 128;
                e = int'(word[31:24]) - 128;
                res[23:0]  = pixel_rgb(word[7:0], d, e);
                res[47:24] = pixel_rgb(word[23:16], d, e);
                add_luma(x, y, word[7:0]);
                add_luma(x + 1, y, word[23:16]);
            end
            ACT_READ: begin
                if (x < IMG_W && y < IMG_H) begin
                    idx = y * IMG_W + x;
                    q = (pred_sums.exists(idx) ? pred_sums[idx] : 32'd0)
                        / ((pred_div == 0) ? 32'd1 : 32'(pred_div));
                    res[55:48] = (q > 255) ? 8'd255 : q[7:0];
                end
            end
            ACT_CLEAR: pred_sums.delete();
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // one slave transfer; prediction is made at the accepting edge
    task automatic send_pair(input t_action act, input logic [31:0] word,
                             input logic [9:0] x, input logic [8:0] y);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {5'd0, y, x, word};
        do @(posedge i_clk); while (!s_axis_tready);
        pixel_queue.push_back(predict_transfer(act, word, int'(x), int'(y)));
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_reg(input int idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx[0];
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_COLOR) pred_color = data[0];
        else                  pred_div   = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // wait out every pending result, then let the sequencer settle
    task automatic drain();
        stop_sending();
        wait (pixel_queue.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker, field by field against the oldest expectation
    always @(posedge i_clk) begin
        logic [55:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixel_queue.size() == 0) begin
                $display("%0t: unexpected transfer %h", $time, m_axis_tdata);
                fail_cnt++;
            end else begin
                want = pixel_queue.pop_front();
                for (int f = 0; f < 7; f++)
                    if (want[f*8 +: 8] !== m_axis_tdata[f*8 +: 8]) begin
                        $display("%0t: field %0d expected %h actual %h", $time, f,
                                 want[f*8 +: 8], m_axis_tdata[f*8 +: 8]);
                        fail_cnt++;
                    end
            end
        end
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[yuyv_to_rgb_luma_integrator] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    function automatic logic [9:0] pick_x();
        case ($urandom_range(9))
            0:       return 10'($urandom_range(1023));
            1:       return 10'($urandom_range(639, 634));
            default: return 10'($urandom_range(7));
        endcase
    endfunction

    function automatic logic [8:0] pick_y();
        case ($urandom_range(9))
            0:       return 9'($urandom_range(511));
            1:       return 9'($urandom_range(479, 477));
            default: return 9'($urandom_range(3));
        endcase
    endfunction

    task automatic test_directed();
        send_pair(ACT_CONV, 32'h0000_0000, 10'd0, 9'd0);
        send_pair(ACT_CONV, 32'hFFFF_FFFF, 10'd2, 9'd0);
        send_pair(ACT_CONV, 32'h80FF_8000, 10'd1, 9'd0);     // odd column
        send_pair(ACT_CONV, 32'h00FF_FF10, 10'd638, 9'd479); // last pair in image
        send_pair(ACT_CONV, 32'hFF40_00C0, 10'd639, 9'd479); // second pixel off the edge
        send_pair(ACT_CONV, 32'h1234_5678, 10'd1023, 9'd511); // fully outside
        send_pair(ACT_NONE, 32'hFFFF_FFFF, 10'd3, 9'd0);     // unused code
        send_pair(ACT_READ, 32'h0, 10'd2, 9'd0);
        send_pair(ACT_READ, 32'h0, 10'd639, 9'd479);
        send_pair(ACT_READ, 32'h0, 10'd640, 9'd0);           // read outside
        send_pair(ACT_READ, 32'h0, 10'd0, 9'd480);
        drain();
        write_reg(CFG_COLOR, 16'd0);
        write_reg(CFG_DIV, 16'd0);                           // zero acts as one
        send_pair(ACT_CONV, 32'hFFFF_FFFF, 10'd2, 9'd0);
        send_pair(ACT_READ, 32'h0, 10'd3, 9'd0);
        drain();
        write_reg(CFG_DIV, 16'hFFFF);
        send_pair(ACT_READ, 32'h0, 10'd3, 9'd0);
        send_pair(ACT_CLEAR, 32'hFFFF_FFFF, 10'd1023, 9'd511);
        send_pair(ACT_READ, 32'h0, 10'd3, 9'd0);
        drain();
        write_reg(CFG_COLOR, 16'd1);
        write_reg(CFG_DIV, 16'd1);
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        t_action act;
        int      r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            act = (r < 60) ? ACT_CONV : (r < 95) ? ACT_READ : ACT_NONE;
            send_pair(act, $urandom, pick_x(), pick_y());
        end
        drain();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge i_clk);
        hold_cycles = 300;
        for (int i = 0; i < 12; i++)
            send_pair(ACT_CONV, $urandom, 10'($urandom_range(7)), 9'd1);
        drain();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = 1'b0;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ACT_NONE;
        m_axis_tready  = 1'b0;
        hold_cycles    = 0;
        quiet_cycles   = 0;
        fail_cnt       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pred_color     = 1'b1;
        pred_div       = 16'd1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(310, 0, 0);
        write_reg(CFG_DIV, 16'd2);
        test_random(310, 51, 0);
        write_reg(CFG_COLOR, 16'd0);
        write_reg(CFG_DIV, 16'd3);
        test_random(310, 0, 51);
        write_reg(CFG_COLOR, 16'd1);
        write_reg(CFG_DIV, 16'($urandom_range(65535, 1)));
        test_random(100, 11, 11);
        write_reg(CFG_DIV, 16'd1);
        test_random(220, 11, 11);
        test_backpressure();

        repeat (30) @(posedge i_clk);
        if (fail_cnt == 0 && pixel_queue.size() == 0)
            $display("[yuyv_to_rgb_luma_integrator] OK");
        else
            $display("[yuyv_to_rgb_luma_integrator] ERROR");
        $finish;
    end

endmodule
